// ===== rtl/circle_obstacle_penalty_defines.svh =====
// assertion macros for the circle obstacle penalty checker
// expects clk_i and rst_ni in the scope that uses them
`ifndef CIRCLE_OBSTACLE_PENALTY_DEFINES_SVH
`define CIRCLE_OBSTACLE_PENALTY_DEFINES_SVH

// implication checked in the same cycle
`define COP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("circle obstacle penalty check failed");

// condition checked at every edge out of reset
`define COP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("circle obstacle penalty check failed");

`endif

// ===== rtl/cop_pkg.sv =====
// shared constants and types for the circle obstacle penalty block
// no dependencies
package cop_pkg;

  localparam int COORD_W    = 32;
  localparam int LEN_W      = 31;
  localparam int PEN_W      = 32;
  localparam int GRAD_W     = 18;
  localparam int GRAD_FRAC  = 16;
  localparam int UNIT_W     = GRAD_FRAC + 1;
  localparam int ROOT_W     = 33;
  localparam int SQRT_STEPS = 33;
  localparam int SQ_REM_W   = 37;
  localparam int DIV_STEPS  = 32;
  localparam int DIVD_W     = 64;
  localparam int DIVS_W     = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER   = 2'd3;

  typedef enum logic [1:0] {
    ZONE_VALID   = 2'd0,
    ZONE_RISK    = 2'd1,
    ZONE_INVALID = 2'd2
  } zone_e;

  typedef struct packed {
    logic              vld;
    logic              pos_x;
    logic              pos_y;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
  } geo_t;

  typedef struct packed {
    logic             vld;
    zone_e            zone;
    logic             nz;
    logic             pos_x;
    logic             pos_y;
    logic [LEN_W-1:0] depth;
    logic [PEN_W-1:0] pen_inv;
  } lane1_t;

  typedef struct packed {
    logic              vld;
    zone_e             zone;
    logic              nz;
    logic              pos_x;
    logic              pos_y;
    logic [PEN_W-1:0]  pen;
    logic [UNIT_W-1:0] ux;
    logic [UNIT_W-1:0] uy;
  } lane2_t;

endpackage

// ===== rtl/cop_in_if.sv =====
// input channel carrying one query point per item
// no dependencies
interface cop_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink (input valid, input point_x, input point_y, output ready);
endinterface

// ===== rtl/cop_out_if.sv =====
// output channel carrying zone, penalty and gradient per item
// no dependencies
interface cop_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         zone;
  logic [31:0]        penalty;
  logic signed [17:0] grad_x;
  logic signed [17:0] grad_y;

  modport source (output valid, output zone, output penalty, output grad_x, output grad_y,
                  input ready);
  modport sink (input valid, input zone, input penalty, input grad_x, input grad_y,
                output ready);
endinterface

// ===== rtl/cop_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on cop_pkg; quotient is exact when it fits in DIV_STEPS bits
module cop_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cop_pkg::DIVD_W-1:0] dividend_i,
  input  logic [cop_pkg::DIVS_W-1:0] divisor_i,
  output logic [cop_pkg::DIV_STEPS-1:0] quotient_o
);
  import cop_pkg::*;

  logic [DIVD_W-1:0]    rem_q [DIV_STEPS];
  logic [DIVS_W-1:0]    den_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DIVD_W-1:0]    rem_in;
    logic [DIVS_W-1:0]    den_in;
    logic [DIV_STEPS-1:0] quo_in;
    logic [DIVD_W-1:0]    trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = dividend_i;
      assign den_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = DIVD_W'(den_in) << (DIV_STEPS - 1 - k);
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_in - trial : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[DIV_STEPS-2:0], ge};
      end
    end
  end

  assign quotient_o = quo_q[DIV_STEPS-1];

endmodule

// ===== rtl/circle_obstacle_penalty.sv =====
// circle obstacle penalty top level: offset, square root, zone, cost and gradient
// depends on cop_pkg, cop_in_if, cop_out_if and cop_div
//
//   channel  | dir | payload                              | handshake
//   in_ch    | in  | point_x, point_y                     | valid / ready
//   out_ch   | out | zone, penalty, grad_x, grad_y        | valid / ready
//   cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i      | write enable only
//
// one item per cycle while out_ch is not stalled
// the pipeline holds the 33 root stages and two 32-stage divider chains in series
// reset clears the configuration, valid and lane registers to zero and empties the pipeline
// a stall on out_ch freezes every stage at once, in_ch ready follows it
module circle_obstacle_penalty (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cop_in_if.sink                        in_ch,
  cop_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [cop_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cop_pkg::COORD_W-1:0]   cfg_data_i
);
  import cop_pkg::*;

  logic [COORD_W-1:0] cx_q, cy_q;
  logic [LEN_W-1:0]   rad_q, buf_q;
  logic               en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      rad_q <= '0;
      buf_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X: cx_q  <= cfg_data_i;
        REG_CENTER_Y: cy_q  <= cfg_data_i;
        REG_RADIUS:   rad_q <= cfg_data_i[LEN_W-1:0];
        REG_BUFFER:   buf_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic               out_vld_q;
  assign en          = !out_vld_q || out_ch.ready;
  assign in_ch.ready = en;

  // offsets
  logic               s0_vld_q;
  logic [COORD_W:0]   s0_dx_q, s0_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_dx_q <= {in_ch.point_x[COORD_W-1], in_ch.point_x} - {cx_q[COORD_W-1], cx_q};
      s0_dy_q <= {in_ch.point_y[COORD_W-1], in_ch.point_y} - {cy_q[COORD_W-1], cy_q};
    end
  end

  // magnitudes
  geo_t             s1_geo_d, s1_geo_q, s2_geo_q, s3_geo_q;
  logic [COORD_W:0] ndx, ndy;

  always_comb begin
    ndx            = (COORD_W+1)'(0) - s0_dx_q;
    ndy            = (COORD_W+1)'(0) - s0_dy_q;
    s1_geo_d.vld   = s0_vld_q;
    s1_geo_d.pos_x = !s0_dx_q[COORD_W] && (s0_dx_q != '0);
    s1_geo_d.pos_y = !s0_dy_q[COORD_W] && (s0_dy_q != '0);
    s1_geo_d.ax    = s0_dx_q[COORD_W] ? ndx[COORD_W-1:0] : s0_dx_q[COORD_W-1:0];
    s1_geo_d.ay    = s0_dy_q[COORD_W] ? ndy[COORD_W-1:0] : s0_dy_q[COORD_W-1:0];
  end

  // squares and their sum
  logic [2*COORD_W-1:0] s2_sx_q, s2_sy_q;
  logic [2*COORD_W:0]   s3_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_geo_q <= '0;
      s2_geo_q <= '0;
      s3_geo_q <= '0;
    end else if (en) begin
      s1_geo_q <= s1_geo_d;
      s2_geo_q <= s1_geo_q;
      s3_geo_q <= s2_geo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sx_q  <= (2*COORD_W)'(s1_geo_q.ax) * (2*COORD_W)'(s1_geo_q.ax);
      s2_sy_q  <= (2*COORD_W)'(s1_geo_q.ay) * (2*COORD_W)'(s1_geo_q.ay);
      s3_sum_q <= {1'b0, s2_sx_q} + {1'b0, s2_sy_q};
    end
  end

  // square root, one root bit per stage
  logic [SQ_REM_W-1:0]  sq_rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0]    sq_root_q [SQRT_STEPS];
  logic [2*COORD_W:0]   sq_rad_q  [SQRT_STEPS];
  geo_t                 sq_geo_q  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [SQ_REM_W-1:0] rem_in, rem_sh, trial;
    logic [ROOT_W-1:0]   root_in;
    logic [2*COORD_W:0]  rad_in;
    logic [2*COORD_W+1:0] rad_ext;
    geo_t                geo_in;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = s3_sum_q;
      assign geo_in  = s3_geo_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign rad_in  = sq_rad_q[k-1];
      assign geo_in  = sq_geo_q[k-1];
    end

    assign rad_ext = {1'b0, rad_in};
    assign rem_sh  = {rem_in[SQ_REM_W-3:0], rad_ext[2*(SQRT_STEPS-1-k) +: 2]};
    assign trial   = SQ_REM_W'({root_in, 2'b01});
    assign ge      = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        sq_root_q[k] <= {root_in[ROOT_W-2:0], ge};
        sq_rad_q[k]  <= rad_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_geo_q[k] <= '0;
      end else if (en) begin
        sq_geo_q[k] <= geo_in;
      end
    end
  end

  // zone decision
  logic [ROOT_W-1:0] n;
  geo_t              ngeo;
  logic [LEN_W:0]    rb;
  lane1_t            p0_d, p0_q, p1_q;
  logic [DIVS_W-1:0] p0_n_q, p1_n_q;
  logic [COORD_W-1:0] p0_ax_q, p0_ay_q, p1_ax_q, p1_ay_q;
  logic [2*LEN_W-1:0] p1_dsq_q;
  logic [PEN_W-1:0]   rb_n;

  assign n    = sq_root_q[SQRT_STEPS-1];
  assign ngeo = sq_geo_q[SQRT_STEPS-1];

  always_comb begin
    rb           = {1'b0, rad_q} + {1'b0, buf_q};
    rb_n         = rb - n[PEN_W-1:0];
    p0_d.vld     = ngeo.vld;
    p0_d.nz      = n != '0;
    p0_d.pos_x   = ngeo.pos_x;
    p0_d.pos_y   = ngeo.pos_y;
    p0_d.depth   = rb_n[LEN_W-1:0];
    p0_d.pen_inv = {1'b0, rad_q} - n[PEN_W-1:0] + {2'b00, buf_q[LEN_W-1:1]};
    if (n >= ROOT_W'(rb)) begin
      p0_d.zone = ZONE_VALID;
    end else if (n >= ROOT_W'(rad_q) && buf_q != '0) begin
      p0_d.zone = ZONE_RISK;
    end else begin
      p0_d.zone = ZONE_INVALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q <= '0;
      p1_q <= '0;
    end else if (en) begin
      p0_q <= p0_d;
      p1_q <= p0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_n_q   <= n[DIVS_W-1:0];
      p0_ax_q  <= ngeo.ax;
      p0_ay_q  <= ngeo.ay;
      p1_n_q   <= p0_n_q;
      p1_ax_q  <= p0_ax_q;
      p1_ay_q  <= p0_ay_q;
      p1_dsq_q <= (2*LEN_W)'(p0_q.depth) * (2*LEN_W)'(p0_q.depth);
    end
  end

  // unit vector and quadratic cost
  logic [DIV_STEPS-1:0] q_ux, q_uy, q_pen;
  lane1_t               d1_q [DIV_STEPS];

  cop_div u_div_ux (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (DIVD_W'({p1_ax_q, GRAD_FRAC'(0)})),
    .divisor_i  (p1_n_q),
    .quotient_o (q_ux)
  );

  cop_div u_div_uy (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (DIVD_W'({p1_ay_q, GRAD_FRAC'(0)})),
    .divisor_i  (p1_n_q),
    .quotient_o (q_uy)
  );

  cop_div u_div_pen (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (DIVD_W'(p1_dsq_q)),
    .divisor_i  ({buf_q, 1'b0}),
    .quotient_o (q_pen)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STEPS; i++) d1_q[i] <= '0;
    end else if (en) begin
      d1_q[0] <= p1_q;
      for (int i = 1; i < DIV_STEPS; i++) d1_q[i] <= d1_q[i-1];
    end
  end

  // penalty select and band scaling product
  lane1_t               a_side;
  lane2_t               m_d, m_q;
  logic [UNIT_W+LEN_W-1:0] m_px_q, m_py_q;

  assign a_side = d1_q[DIV_STEPS-1];

  always_comb begin
    m_d.vld   = a_side.vld;
    m_d.zone  = a_side.zone;
    m_d.nz    = a_side.nz;
    m_d.pos_x = a_side.pos_x;
    m_d.pos_y = a_side.pos_y;
    m_d.ux    = q_ux[UNIT_W-1:0];
    m_d.uy    = q_uy[UNIT_W-1:0];
    case (a_side.zone)
      ZONE_RISK:    m_d.pen = q_pen;
      ZONE_INVALID: m_d.pen = a_side.pen_inv;
      default:      m_d.pen = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= '0;
    end else if (en) begin
      m_q <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_px_q <= (UNIT_W+LEN_W)'(q_ux[UNIT_W-1:0]) * (UNIT_W+LEN_W)'(a_side.depth);
      m_py_q <= (UNIT_W+LEN_W)'(q_uy[UNIT_W-1:0]) * (UNIT_W+LEN_W)'(a_side.depth);
    end
  end

  // band gradient
  logic [DIV_STEPS-1:0] q_gx, q_gy;
  lane2_t               d2_q [DIV_STEPS];

  cop_div u_div_gx (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (DIVD_W'(m_px_q)),
    .divisor_i  ({1'b0, buf_q}),
    .quotient_o (q_gx)
  );

  cop_div u_div_gy (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (DIVD_W'(m_py_q)),
    .divisor_i  ({1'b0, buf_q}),
    .quotient_o (q_gy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STEPS; i++) d2_q[i] <= '0;
    end else if (en) begin
      d2_q[0] <= m_q;
      for (int i = 1; i < DIV_STEPS; i++) d2_q[i] <= d2_q[i-1];
    end
  end

  // output register
  lane2_t            b_side;
  logic [UNIT_W-1:0] mag_x, mag_y;
  logic [GRAD_W-1:0] gx_d, gy_d;
  logic [1:0]        out_zone_q;
  logic [PEN_W-1:0]  out_pen_q;
  logic [GRAD_W-1:0] out_gx_q, out_gy_q;

  assign b_side = d2_q[DIV_STEPS-1];

  always_comb begin
    case (b_side.zone)
      ZONE_RISK: begin
        mag_x = q_gx[UNIT_W-1:0];
        mag_y = q_gy[UNIT_W-1:0];
      end
      ZONE_INVALID: begin
        mag_x = b_side.ux;
        mag_y = b_side.uy;
      end
      default: begin
        mag_x = '0;
        mag_y = '0;
      end
    endcase
    if (!b_side.nz) begin
      mag_x = '0;
      mag_y = '0;
    end
    gx_d = b_side.pos_x ? GRAD_W'(0) - GRAD_W'(mag_x) : GRAD_W'(mag_x);
    gy_d = b_side.pos_y ? GRAD_W'(0) - GRAD_W'(mag_y) : GRAD_W'(mag_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= b_side.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_zone_q <= b_side.zone;
      out_pen_q  <= b_side.pen;
      out_gx_q   <= gx_d;
      out_gy_q   <= gy_d;
    end
  end

  assign out_ch.valid   = out_vld_q;
  assign out_ch.zone    = out_zone_q;
  assign out_ch.penalty = out_pen_q;
  assign out_ch.grad_x  = out_gx_q;
  assign out_ch.grad_y  = out_gy_q;

endmodule

// ===== rtl/cop_checker.sv =====
// port-level checks for the circle obstacle penalty block
// depends on cop_pkg and circle_obstacle_penalty_defines.svh; bound to the top level
`include "circle_obstacle_penalty_defines.svh"

module cop_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic [1:0]  zone_i,
  input logic [31:0] penalty_i,
  input logic [17:0] grad_x_i,
  input logic [17:0] grad_y_i
);
  import cop_pkg::*;

  // no backpressure on the input while the output is empty
  `COP_ASSERT_IMPL(a_ready_when_empty, !out_valid_i, in_ready_i)

  // a valid point carries no cost and no gradient
  `COP_ASSERT_IMPL(a_valid_zone_zero, out_valid_i && zone_i == ZONE_VALID, penalty_i == '0 && grad_x_i == '0 && grad_y_i == '0)

  // a point inside the obstacle always costs something
  `COP_ASSERT_IMPL(a_invalid_costs, out_valid_i && zone_i == ZONE_INVALID, penalty_i != '0)

  // gradient components stay within one unit
  `COP_ASSERT_IMPL(a_grad_range, out_valid_i, $signed(grad_x_i) >= -18'sd65536 && $signed(grad_x_i) <= 18'sd65536 && $signed(grad_y_i) >= -18'sd65536 && $signed(grad_y_i) <= 18'sd65536)

endmodule

bind circle_obstacle_penalty cop_checker u_cop_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .zone_i      (out_ch.zone),
  .penalty_i   (out_ch.penalty),
  .grad_x_i    (out_ch.grad_x),
  .grad_y_i    (out_ch.grad_y)
);
